// File: rtl/fre_pkg.sv
`default_nettype none

package fre_pkg;

   localparam int unsigned ENTRY_BYTES      = 32;
   localparam int unsigned NAME_BYTES       = 11;
   localparam int unsigned VOLUME_LABEL_BIT = 3;

   localparam logic [4:0] LAST_POS      = 5'(ENTRY_BYTES - 1);
   localparam logic [4:0] NAME_END_POS  = 5'(NAME_BYTES);
   localparam logic [4:0] CLUSTER_LO    = 5'd26;
   localparam logic [4:0] CLUSTER_HI    = 5'd27;
   localparam logic [4:0] SIZE_POS      = 5'd28;
   localparam logic [7:0] DELETED_MARK  = 8'hE5;
   localparam logic [7:0] END_MARK      = 8'h00;

   localparam logic [1:0] CSR_BASE_NAME   = 2'd0;
   localparam logic [1:0] CSR_EXTENSION   = 2'd1;
   localparam logic [1:0] CSR_ENTRY_LIMIT = 2'd2;

   localparam logic [63:0] BASE_NAME_RESET   = 64'h2020_2020_2020_2020;
   localparam logic [23:0] EXTENSION_RESET   = 24'h20_2020;
   localparam logic [15:0] ENTRY_LIMIT_RESET = 16'd224;

   typedef struct packed {
      logic [63:0] base_name;
      logic [23:0] extension;
      logic [15:0] entry_limit;
   } fre_cfg_type;

   typedef struct packed {
      logic        valid;
      logic        found;
      logic [15:0] start_cluster;
      logic [31:0] file_size;
      logic [15:0] entry_number;
   } fre_result_type;

endpackage

`default_nettype wire

// File: rtl/fre_scan.sv
`default_nettype none

module fre_scan (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire logic [7:0]              dir_byte,
   input  wire logic                    dir_start,
   input  wire fre_pkg::fre_cfg_type    cfg,
   output fre_pkg::fre_result_type      result
);

   logic [4:0]  pos_ff,  pos_in;
   logic [15:0] cnt_ff,  cnt_in;
   logic        eq_ff,   eq_in;
   logic        skip_ff, skip_in;
   logic [7:0]  attr_ff, attr_in;
   logic [15:0] cl_ff,   cl_in;
   logic [31:0] sz_ff,   sz_in;
   logic        done_ff, done_in;

   logic [87:0] name_word;
   assign name_word = {cfg.extension, cfg.base_name};

   always_comb begin
      logic        go;
      logic [4:0]  cur_pos;
      logic [15:0] cur_cnt;
      logic [15:0] cnt_inc;
      logic [7:0]  want;
      logic        unused;
      logic        label;

      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      eq_in   = eq_ff;
      skip_in = skip_ff;
      attr_in = attr_ff;
      cl_in   = cl_ff;
      sz_in   = sz_ff;
      done_in = done_ff;
      result  = '0;
      go      = 1'b0;
      cur_pos = pos_ff;
      cur_cnt = cnt_ff;
      cnt_inc = '0;
      want    = '0;
      unused  = 1'b0;
      label   = 1'b0;

      if (fire) begin
         if (dir_start) begin
            pos_in  = '0;
            cnt_in  = '0;
            eq_in   = 1'b1;
            skip_in = 1'b0;
            attr_in = '0;
            cl_in   = '0;
            sz_in   = '0;
            done_in = 1'b0;
            cur_pos = '0;
            cur_cnt = '0;
            if (cfg.entry_limit == '0) begin
               result.valid = 1'b1;
               done_in      = 1'b1;
            end else begin
               go = 1'b1;
            end
         end else if (!done_ff) begin
            go = 1'b1;
         end

         if (go) begin
            if (cur_pos == '0 && dir_byte == fre_pkg::END_MARK) begin
               result.valid        = 1'b1;
               result.entry_number = cur_cnt;
               done_in             = 1'b1;
            end else begin
               if (cur_pos == '0 && dir_byte == fre_pkg::DELETED_MARK) begin
                  skip_in = 1'b1;
               end
               if (cur_pos < fre_pkg::NAME_END_POS) begin
                  want = name_word[{cur_pos[3:0], 3'b000} +: 8];
                  if (dir_byte != want) begin
                     eq_in = 1'b0;
                  end
               end else if (cur_pos == fre_pkg::NAME_END_POS) begin
                  attr_in = dir_byte;
               end else if (cur_pos == fre_pkg::CLUSTER_LO) begin
                  cl_in[7:0] = dir_byte;
               end else if (cur_pos == fre_pkg::CLUSTER_HI) begin
                  cl_in[15:8] = dir_byte;
               end else if (cur_pos >= fre_pkg::SIZE_POS) begin
                  sz_in[{cur_pos[1:0], 3'b000} +: 8] = dir_byte;
               end

               if (cur_pos != fre_pkg::LAST_POS) begin
                  pos_in = cur_pos + 5'd1;
               end else begin
                  unused = (attr_in == '0) && (cl_in == '0);
                  label  = attr_in[fre_pkg::VOLUME_LABEL_BIT];
                  if (!skip_in && !unused && !label && eq_in) begin
                     result.valid         = 1'b1;
                     result.found         = 1'b1;
                     result.start_cluster = cl_in;
                     result.file_size     = sz_in;
                     result.entry_number  = cur_cnt;
                     done_in              = 1'b1;
                  end else begin
                     cnt_inc = cur_cnt + 16'd1;
                     pos_in  = '0;
                     eq_in   = 1'b1;
                     skip_in = 1'b0;
                     attr_in = '0;
                     cl_in   = '0;
                     sz_in   = '0;
                     cnt_in  = cnt_inc;
                     if (cnt_inc >= cfg.entry_limit) begin
                        result.valid        = 1'b1;
                        result.entry_number = cnt_inc;
                        done_in             = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         cnt_ff  <= '0;
         eq_ff   <= 1'b1;
         skip_ff <= 1'b0;
         attr_ff <= '0;
         cl_ff   <= '0;
         sz_ff   <= '0;
         done_ff <= 1'b1;
      end else begin
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
         eq_ff   <= eq_in;
         skip_ff <= skip_in;
         attr_ff <= attr_in;
         cl_ff   <= cl_in;
         sz_ff   <= sz_in;
         done_ff <= done_in;
      end
   end

   a_result_ends_search: assert property (@(posedge clock) disable iff (reset)
      result.valid |=> done_ff)
      else $error("search still live after a result beat");

   a_idle_without_start: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !(fire && dir_start)) |-> !result.valid)
      else $error("result beat from an idle search");

endmodule

`default_nettype wire

// File: rtl/fat_root_entry_finder.sv
`default_nettype none
// A request beat passes the request register, then the response register.
// Throughput: one directory byte per cycle; the request register and the
// response register each take a beat per cycle while the response side drains.
// Reset: synchronous, active high; the search idles until a start byte,
// the target registers return to a blank 8.3 name and a limit of 224 entries.

module fat_root_entry_finder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_dir_byte,
   input  wire logic        req_dir_start,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_found,
   output      logic [15:0] rsp_start_cluster,
   output      logic [31:0] rsp_file_size,
   output      logic [15:0] rsp_entry_number,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   fre_pkg::fre_cfg_type    cfg_ff;
   fre_pkg::fre_result_type result;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic        process;

   logic        rsp_valid_ff;
   logic        rsp_found_ff;
   logic [15:0] rsp_cluster_ff;
   logic [31:0] rsp_size_ff;
   logic [15:0] rsp_entry_ff;

   assign csr_ready = 1'b1;
   assign process   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_name   <= fre_pkg::BASE_NAME_RESET;
         cfg_ff.extension   <= fre_pkg::EXTENSION_RESET;
         cfg_ff.entry_limit <= fre_pkg::ENTRY_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            fre_pkg::CSR_BASE_NAME:   cfg_ff.base_name   <= csr_data;
            fre_pkg::CSR_EXTENSION:   cfg_ff.extension   <= csr_data[23:0];
            fre_pkg::CSR_ENTRY_LIMIT: cfg_ff.entry_limit <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_byte_ff  <= req_dir_byte;
         in_start_ff <= req_dir_start;
      end
   end

   fre_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .fire      (process),
      .dir_byte  (in_byte_ff),
      .dir_start (in_start_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process && result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (process && result.valid) begin
         rsp_found_ff   <= result.found;
         rsp_cluster_ff <= result.start_cluster;
         rsp_size_ff    <= result.file_size;
         rsp_entry_ff   <= result.entry_number;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_start_cluster = rsp_cluster_ff;
   assign rsp_file_size     = rsp_size_ff;
   assign rsp_entry_number  = rsp_entry_ff;

   a_miss_has_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_start_cluster == '0 && rsp_file_size == '0))
      else $error("not-found beat carries cluster or size");

   a_held_byte_stays: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ready) |=>
         (in_valid_ff && $stable(in_byte_ff) && $stable(in_start_ff)))
      else $error("held request byte lost while response stalls");

   a_empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("empty request stage refuses a beat");

endmodule

`default_nettype wire

// File: test/fat_root_entry_finder_tb.sv
`default_nettype none

module fat_root_entry_finder_tb;

   typedef struct packed {
      logic        found;
      logic [15:0] start_cluster;
      logic [31:0] file_size;
      logic [15:0] entry_number;
   } lookup_result_type;

   typedef enum int {
      ENT_MATCH,
      ENT_MISS,
      ENT_DELETED,
      ENT_LABEL,
      ENT_UNUSED,
      ENT_NOISE,
      ENT_END
   } entry_kind_type;

   localparam logic [1:0]  CSR_UNMAPPED = 2'd3;
   localparam logic [63:0] README_NAME  = 64'h2020_454D_4441_4552;
   localparam logic [23:0] TXT_EXT      = 24'h54_5854;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_REPORTS  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_dir_byte = '0;
   logic        req_dir_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_found;
   logic [15:0] rsp_start_cluster;
   logic [31:0] rsp_file_size;
   logic [15:0] rsp_entry_number;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0] cfg_name  = fre_pkg::BASE_NAME_RESET;
   logic [23:0] cfg_ext   = fre_pkg::EXTENSION_RESET;
   logic [15:0] cfg_limit = fre_pkg::ENTRY_LIMIT_RESET;

   logic [4:0]  scan_pos = '0;
   logic [15:0] scan_entry = '0;
   logic        scan_equal = 1'b1;
   logic        scan_skip = 1'b0;
   logic [7:0]  scan_attr = '0;
   logic [15:0] scan_cluster = '0;
   logic [31:0] scan_size = '0;
   logic        scan_done = 1'b1;

   lookup_result_type lookups_pending[$];
   logic [7:0]        dir_entry [32];

   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int fail_count = 0;
   int lookups_seen = 0;
   int bytes_examined = 0;
   int cycle_count = 0;

   fat_root_entry_finder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_dir_byte      (req_dir_byte),
      .req_dir_start     (req_dir_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_start_cluster (rsp_start_cluster),
      .rsp_file_size     (rsp_file_size),
      .rsp_entry_number  (rsp_entry_number),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] target_byte(int k);
      return (k < 8) ? cfg_name[8*k +: 8] : cfg_ext[8*(k-8) +: 8];
   endfunction

   function automatic void clear_scan();
      scan_pos = '0;
      scan_equal = 1'b1;
      scan_skip = 1'b0;
      scan_attr = '0;
      scan_cluster = '0;
      scan_size = '0;
   endfunction

   function automatic void post_lookup(logic hit, logic [15:0] cluster, logic [31:0] size,
                                       logic [15:0] idx);
      lookups_pending.push_back('{hit, cluster, size, idx});
      scan_done = 1'b1;
   endfunction

   function automatic void scan_dir_byte(logic [7:0] b, logic s);
      int k;
      if (s) begin
         clear_scan();
         scan_entry = '0;
         scan_done = 1'b0;
         if (cfg_limit == 0) begin
            post_lookup(1'b0, '0, '0, '0);
            return;
         end
      end else if (scan_done) begin
         return;
      end
      k = scan_pos;
      if (k == 0 && b == fre_pkg::END_MARK) begin
         post_lookup(1'b0, '0, '0, scan_entry);
         return;
      end
      if (k == 0 && b == fre_pkg::DELETED_MARK)
         scan_skip = 1'b1;
      if (k < fre_pkg::NAME_BYTES) begin
         if (b != target_byte(k))
            scan_equal = 1'b0;
      end else if (k == fre_pkg::NAME_END_POS) begin
         scan_attr = b;
      end else if (k == fre_pkg::CLUSTER_LO) begin
         scan_cluster[7:0] = b;
      end else if (k == fre_pkg::CLUSTER_HI) begin
         scan_cluster[15:8] = b;
      end else if (k >= fre_pkg::SIZE_POS) begin
         scan_size[8*(k-fre_pkg::SIZE_POS) +: 8] = b;
      end
      if (k != fre_pkg::LAST_POS) begin
         scan_pos = scan_pos + 1'b1;
         return;
      end
      if (!scan_skip && !(scan_attr == 0 && scan_cluster == 0) &&
          !scan_attr[fre_pkg::VOLUME_LABEL_BIT] && scan_equal) begin
         post_lookup(1'b1, scan_cluster, scan_size, scan_entry);
         return;
      end
      clear_scan();
      scan_entry = scan_entry + 1'b1;
      if (scan_entry >= cfg_limit)
         post_lookup(1'b0, '0, '0, scan_entry);
   endfunction

   task automatic send_dir_byte(input logic [7:0] b, input logic s);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dir_byte <= b;
      req_dir_start <= s;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (s || !scan_done)
         bytes_examined++;
      scan_dir_byte(b, s);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         fre_pkg::CSR_BASE_NAME:   cfg_name = data;
         fre_pkg::CSR_EXTENSION:   cfg_ext = data[23:0];
         fre_pkg::CSR_ENTRY_LIMIT: cfg_limit = data[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [63:0] name, input logic [23:0] ext,
                            input logic [15:0] limit);
      write_csr(fre_pkg::CSR_BASE_NAME, name);
      write_csr(fre_pkg::CSR_EXTENSION, {32'($urandom), 8'($urandom_range(255)), ext});
      write_csr(fre_pkg::CSR_ENTRY_LIMIT,
                {32'($urandom), 16'($urandom_range(65535)), limit});
      csr_valid <= 1'b0;
   endtask

   // drop valid, drain every pending result, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (lookups_pending.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic build_entry(input entry_kind_type kind);
      int k;
      for (k = 0; k < fre_pkg::ENTRY_BYTES; k++)
         dir_entry[k] = 8'($urandom_range(255));
      if (kind != ENT_NOISE)
         for (k = 0; k < fre_pkg::NAME_BYTES; k++)
            dir_entry[k] = target_byte(k);
      case (kind)
         ENT_MATCH: begin
            if ($urandom_range(4) == 0)
               dir_entry[fre_pkg::NAME_END_POS] = '0;
            else if ($urandom_range(3) == 0) begin
               dir_entry[fre_pkg::CLUSTER_LO] = '0;
               dir_entry[fre_pkg::CLUSTER_HI] = '0;
            end
            dir_entry[fre_pkg::NAME_END_POS][fre_pkg::VOLUME_LABEL_BIT] = 1'b0;
            if (dir_entry[fre_pkg::NAME_END_POS] == 0 && dir_entry[fre_pkg::CLUSTER_LO] == 0 &&
                dir_entry[fre_pkg::CLUSTER_HI] == 0)
               dir_entry[fre_pkg::CLUSTER_LO] = 8'h01;
         end
         ENT_MISS: begin
            k = $urandom_range(fre_pkg::NAME_BYTES - 1);
            dir_entry[k] = dir_entry[k] ^ 8'($urandom_range(1, 255));
         end
         ENT_DELETED: dir_entry[0] = fre_pkg::DELETED_MARK;
         ENT_LABEL:   dir_entry[fre_pkg::NAME_END_POS][fre_pkg::VOLUME_LABEL_BIT] = 1'b1;
         ENT_UNUSED: begin
            dir_entry[fre_pkg::NAME_END_POS] = '0;
            dir_entry[fre_pkg::CLUSTER_LO] = '0;
            dir_entry[fre_pkg::CLUSTER_HI] = '0;
         end
         ENT_END: dir_entry[0] = fre_pkg::END_MARK;
         default: ;
      endcase
   endtask

   task automatic put_fields(input logic [7:0] attr, input logic [15:0] cluster,
                             input logic [31:0] size);
      int k;
      dir_entry[fre_pkg::NAME_END_POS] = attr;
      dir_entry[fre_pkg::CLUSTER_LO] = cluster[7:0];
      dir_entry[fre_pkg::CLUSTER_HI] = cluster[15:8];
      for (k = 0; k < 4; k++)
         dir_entry[fre_pkg::SIZE_POS + k] = size[8*k +: 8];
   endtask

   task automatic send_entry(input logic first_start);
      int k;
      for (k = 0; k < fre_pkg::ENTRY_BYTES; k++) begin
         send_dir_byte(dir_entry[k], first_start && k == 0);
         if (scan_done)
            break;
      end
   endtask

   function automatic logic [63:0] random_name_bytes();
      logic [63:0] v;
      int len;
      int k;
      if ($urandom_range(2) == 0)
         return {$urandom, $urandom};
      len = $urandom_range(1, 8);
      for (k = 0; k < 8; k++)
         v[8*k +: 8] = (k < len) ? 8'(8'h41 + $urandom_range(25)) : 8'h20;
      return v;
   endfunction

   task automatic random_config();
      logic [63:0] name;
      logic [63:0] ext;
      logic [15:0] limit;
      name = random_name_bytes();
      ext = random_name_bytes();
      case ($urandom_range(9))
         0:       limit = '0;
         1:       limit = 16'hFFFF;
         2:       limit = fre_pkg::ENTRY_LIMIT_RESET;
         default: limit = 16'($urandom_range(1, 6));
      endcase
      configure(name, ext[23:0], limit);
   endtask

   function automatic entry_kind_type pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 25) return ENT_MATCH;
      if (r < 50) return ENT_MISS;
      if (r < 60) return ENT_DELETED;
      if (r < 70) return ENT_LABEL;
      if (r < 80) return ENT_UNUSED;
      if (r < 95) return ENT_NOISE;
      return ENT_END;
   endfunction

   task automatic random_directory();
      int entries;
      int e;
      int k;
      entries = $urandom_range(1, 6);
      // abandon a directory part way through an entry
      if ($urandom_range(9) == 0) begin
         build_entry(ENT_NOISE);
         k = $urandom_range(1, 31);
         for (e = 0; e < k; e++)
            send_dir_byte(dir_entry[e], e == 0);
      end
      for (e = 0; e < entries && (e == 0 || !scan_done); e++) begin
         build_entry(pick_kind());
         send_entry(e == 0);
      end
      if (!scan_done) begin
         build_entry(ENT_END);
         send_entry(1'b0);
      end
      if ($urandom_range(9) == 0)
         for (k = 0; k < 3; k++)
            send_dir_byte(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic test_ignored_before_start();
      send_dir_byte(fre_pkg::END_MARK, 1'b0);
      send_dir_byte(8'hFF, 1'b0);
      send_dir_byte(fre_pkg::DELETED_MARK, 1'b0);
      wait_idle();
   endtask

   task automatic test_blank_name_after_reset();
      build_entry(ENT_MATCH);
      put_fields(8'h20, 16'hFFFF, 32'hFFFF_FFFF);
      send_entry(1'b1);
      wait_idle();
   endtask

   task automatic test_skipped_entries();
      configure(README_NAME, TXT_EXT, 16'd16);
      build_entry(ENT_DELETED);
      send_entry(1'b1);
      build_entry(ENT_LABEL);
      send_entry(1'b0);
      build_entry(ENT_UNUSED);
      send_entry(1'b0);
      build_entry(ENT_MISS);
      send_entry(1'b0);
      build_entry(ENT_MATCH);
      put_fields(8'h00, 16'h0100, $urandom);
      send_entry(1'b0);
      wait_idle();
      build_entry(ENT_MATCH);
      put_fields(8'h01, 16'h0000, 32'h0);
      send_entry(1'b1);
      wait_idle();
   endtask

   task automatic test_end_marker();
      build_entry(ENT_MISS);
      send_entry(1'b1);
      build_entry(ENT_END);
      send_entry(1'b0);
      wait_idle();
      build_entry(ENT_END);
      send_entry(1'b1);
      wait_idle();
   endtask

   task automatic test_entry_limit();
      int k;
      configure(README_NAME, TXT_EXT, 16'd1);
      build_entry(ENT_MISS);
      send_entry(1'b1);
      wait_idle();
      configure(README_NAME, TXT_EXT, 16'd0);
      build_entry(ENT_MATCH);
      send_entry(1'b1);
      for (k = 1; k < 4; k++)
         send_dir_byte(dir_entry[k], 1'b0);
      wait_idle();
      configure(64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
      build_entry(ENT_MATCH);
      put_fields(8'hF7, 16'h0000, 32'h0);
      send_entry(1'b1);
      wait_idle();
      configure(64'h0, 24'h0, 16'd2);
      build_entry(ENT_MATCH);
      send_entry(1'b1);
      wait_idle();
   endtask

   task automatic test_limit_lowered();
      configure(README_NAME, TXT_EXT, fre_pkg::ENTRY_LIMIT_RESET);
      build_entry(ENT_MISS);
      send_entry(1'b1);
      build_entry(ENT_DELETED);
      send_entry(1'b0);
      build_entry(ENT_MISS);
      send_entry(1'b0);
      wait_idle();
      write_csr(fre_pkg::CSR_ENTRY_LIMIT, 64'd2);
      csr_valid <= 1'b0;
      build_entry(ENT_MISS);
      send_entry(1'b0);
      wait_idle();
   endtask

   task automatic test_restart_mid_entry();
      int k;
      build_entry(ENT_MATCH);
      for (k = 0; k < 9; k++)
         send_dir_byte(dir_entry[k], k == 0);
      build_entry(ENT_MATCH);
      send_entry(1'b1);
      wait_idle();
   endtask

   task automatic test_unmapped_register();
      write_csr(CSR_UNMAPPED, {$urandom, $urandom});
      csr_valid <= 1'b0;
      build_entry(ENT_MATCH);
      send_entry(1'b1);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int gap_pct, input int stall_pct);
      int byte_mark;
      int lookup_mark;
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      byte_mark = bytes_examined;
      lookup_mark = lookups_seen;
      while (bytes_examined - byte_mark < 100 || lookups_seen - lookup_mark < 2) begin
         if ($urandom_range(3) == 0) begin
            wait_idle();
            random_config();
         end
         random_directory();
      end
      wait_idle();
   endtask

   always @(posedge clock) begin : check_lookups
      lookup_result_type want;
      lookup_result_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_found, rsp_start_cluster, rsp_file_size, rsp_entry_number};
            lookups_seen++;
            if (lookups_pending.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected beat: found=%0d cluster=%h size=%h entry=%0d",
                           got.found, got.start_cluster, got.file_size, got.entry_number);
            end else begin
               want = lookups_pending.pop_front();
               if (got.found !== want.found || got.start_cluster !== want.start_cluster ||
                   got.file_size !== want.file_size ||
                   got.entry_number !== want.entry_number) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display({"lookup mismatch: expected found=%0d cluster=%h size=%h",
                               " entry=%0d, got found=%0d cluster=%h size=%h entry=%0d"},
                              want.found, want.start_cluster, want.file_size,
                              want.entry_number, got.found, got.start_cluster,
                              got.file_size, got.entry_number);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : run_tests
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_ignored_before_start();
      test_blank_name_after_reset();
      test_skipped_entries();
      test_end_marker();
      test_entry_limit();
      test_limit_lowered();
      test_restart_mid_entry();
      test_unmapped_register();
      test_random_traffic(0, 0);
      test_random_traffic(62, 0);
      test_random_traffic(0, 62);
      test_random_traffic(28, 28);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
